/* hdl/cts_pkg.sv */
// Shared types and constants for the CAN transmit priority scheduler.
`default_nettype none
package cts_pkg;

	localparam int ID_W = 11;
	localparam int IN_ID_W = 12;
	localparam int LEN_W = 4;
	localparam int PAY_W = 64;
	localparam int SLOT_W = 8;
	localparam int CNT_W = 32;
	localparam int PEAK_W = 7;
	localparam int STATUS_W = 3;
	localparam int MODE_W = 2;

	localparam logic [IN_ID_W-1:0] ID_MAX = 12'd2047;
	localparam logic [LEN_W-1:0] LEN_MAX = 4'd8;

	typedef enum logic [MODE_W-1:0] {
		MODE_URGENT = 2'd0,
		MODE_JOINT  = 2'd1,
		MODE_POP    = 2'd2,
		MODE_BAD    = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_BAD_ARG   = 3'd2,
		ST_BAD_JOINT = 3'd3,
		ST_FULL      = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
		logic [PAY_W-1:0] payload;
	} frame_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic reject;
	} uq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} uq_stat_t;

	typedef struct packed {
		logic write;
		logic pop;
	} js_cmd_t;

	typedef struct packed {
		logic any_pending;
		logic hit;
	} js_stat_t;

endpackage
`default_nettype wire

/* hdl/cts_if.sv */
// Valid/ready channel interfaces for scheduler commands and results.
`default_nettype none
interface cts_req_if;
	logic                         valid;
	logic                         ready;
	logic [cts_pkg::MODE_W-1:0]   mode;
	logic [cts_pkg::SLOT_W-1:0]   joint_slot;
	logic [cts_pkg::IN_ID_W-1:0]  frame_id;
	logic [cts_pkg::LEN_W-1:0]    frame_length;
	logic [cts_pkg::PAY_W-1:0]    frame_payload;

	modport source (output valid, mode, joint_slot, frame_id, frame_length, frame_payload,
		input ready);
	modport sink (input valid, mode, joint_slot, frame_id, frame_length, frame_payload,
		output ready);
endinterface

interface cts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cts_pkg::STATUS_W-1:0]  status;
	logic [cts_pkg::ID_W-1:0]      out_id;
	logic [cts_pkg::LEN_W-1:0]     out_length;
	logic [cts_pkg::PAY_W-1:0]     out_payload;
	logic                          out_priority;
	logic [cts_pkg::CNT_W-1:0]     full_rejects;
	logic [cts_pkg::CNT_W-1:0]     coalesced_total;
	logic [cts_pkg::PEAK_W-1:0]    peak_fill;

	modport source (output valid, status, out_id, out_length, out_payload, out_priority,
		full_rejects, coalesced_total, peak_fill, input ready);
	modport sink (input valid, status, out_id, out_length, out_payload, out_priority,
		full_rejects, coalesced_total, peak_fill, output ready);
endinterface
`default_nettype wire

/* hdl/cts_urgent_queue.sv */
// Emergency frame FIFO: storage memory, head and fill pointers, statistics.
`default_nettype none
module cts_urgent_queue #(
	parameter int DEPTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cts_pkg::uq_cmd_t  cmd,
	input  wire cts_pkg::frame_t   wr_frame,
	output cts_pkg::uq_stat_t      stat,
	output cts_pkg::frame_t        rd_frame,
	output logic [cts_pkg::CNT_W-1:0]  full_rejects,
	output logic [cts_pkg::PEAK_W-1:0] peak_fill
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);
	localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

	cts_pkg::frame_t mem [DEPTH];
	cts_pkg::frame_t rd_q;

	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] peak_q;
	logic [cts_pkg::CNT_W-1:0] rej_q;

	logic [AW:0]   wsum;
	logic [AW:0]   hinc;
	logic [AW-1:0] waddr;
	logic [AW-1:0] head_next;
	logic [FW-1:0] fill_inc;

	always_comb begin
		wsum = {1'b0, head_q} + (AW + 1)'(fill_q);
		if (wsum >= DEPTH_X) begin
			wsum = wsum - DEPTH_X;
		end
		waddr = wsum[AW-1:0];
		hinc = {1'b0, head_q} + 1'b1;
		head_next = (hinc >= DEPTH_X) ? '0 : hinc[AW-1:0];
		fill_inc = fill_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			peak_q <= '0;
			rej_q  <= '0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_inc;
				if (fill_inc > peak_q) begin
					peak_q <= fill_inc;
				end
			end else if (cmd.pop) begin
				fill_q <= fill_q - 1'b1;
				head_q <= head_next;
			end
			if (cmd.reject) begin
				rej_q <= rej_q + 1'b1;
			end
		end
	end

	// Storage with a registered read port; a push and a pop never share an edge.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[waddr] <= wr_frame;
		end
		if (cmd.pop) begin
			rd_q <= mem[head_q];
		end
	end

	assign stat.empty   = (fill_q == '0);
	assign stat.full    = (fill_q == FILL_MAX);
	assign rd_frame     = rd_q;
	assign full_rejects = rej_q;
	assign peak_fill    = cts_pkg::PEAK_W'(peak_q);
endmodule
`default_nettype wire

/* hdl/cts_joint_slots.sv */
// Joint slot memory with pending mask, round-robin selection and coalesce count.
`default_nettype none
module cts_joint_slots #(
	parameter int COUNT = 6,
	localparam int JW = (COUNT > 1) ? $clog2(COUNT) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cts_pkg::js_cmd_t cmd,
	input  wire logic [JW-1:0]    slot,
	input  wire cts_pkg::frame_t  wr_frame,
	output cts_pkg::js_stat_t     stat,
	output cts_pkg::frame_t       rd_frame,
	output logic [cts_pkg::CNT_W-1:0] coalesced_total
);
	localparam logic [JW:0] COUNT_X = (JW + 1)'(COUNT);

	cts_pkg::frame_t mem [COUNT];
	cts_pkg::frame_t rd_q;

	logic [COUNT-1:0] mask_q;
	logic [JW-1:0]    rr_q;
	logic [cts_pkg::CNT_W-1:0] coal_q;

	logic [JW:0]   cand;
	logic [JW:0]   sel_inc;
	logic [JW-1:0] sel;
	logic [JW-1:0] rr_next;
	logic          found;

	// Rotating priority encode, starting at the joint after the last one served.
	always_comb begin
		found = 1'b0;
		sel = '0;
		for (int k = 0; k < COUNT; k++) begin
			cand = {1'b0, rr_q} + (JW + 1)'(k);
			if (cand >= COUNT_X) begin
				cand = cand - COUNT_X;
			end
			if (!found && mask_q[cand[JW-1:0]]) begin
				found = 1'b1;
				sel = cand[JW-1:0];
			end
		end
		sel_inc = {1'b0, sel} + 1'b1;
		rr_next = (sel_inc >= COUNT_X) ? '0 : sel_inc[JW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			rr_q   <= '0;
			coal_q <= '0;
		end else begin
			if (cmd.write) begin
				mask_q[slot] <= 1'b1;
				if (mask_q[slot]) begin
					coal_q <= coal_q + 1'b1;
				end
			end else if (cmd.pop) begin
				mask_q[sel] <= 1'b0;
				rr_q <= rr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[slot] <= wr_frame;
		end
		if (cmd.pop) begin
			rd_q <= mem[sel];
		end
	end

	assign stat.any_pending = found;
	assign stat.hit         = mask_q[slot];
	assign rd_frame         = rd_q;
	assign coalesced_total  = coal_q;
endmodule
`default_nettype wire

/* hdl/can_tx_priority_scheduler.sv */
// Top level of the CAN transmit scheduler: command decode, result stage and output register.
// A command accepted from req passes through the result stage and then the output register
// before its result shows on rsp; a held rsp can keep it waiting in the result stage.
// Throughput: one command transaction per cycle while rsp drains; the limit is the single
// result stage waiting on the output register, which stalls req when rsp is held.
// Reset: arst_n clears the FIFO pointers, pending mask, round-robin pointer and counters
// at once; frame memories are not cleared and are only read after being written.
`default_nettype none
module can_tx_priority_scheduler #(
	parameter int URGENT_DEPTH = 8,
	parameter int JOINT_COUNT = 6
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cts_req_if.sink   req,
	cts_rsp_if.source rsp
);
	localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam logic [cts_pkg::SLOT_W-1:0] JOINT_LIMIT = cts_pkg::SLOT_W'(JOINT_COUNT);

	// Where the popped frame of a command comes from.
	typedef enum logic [1:0] {
		SRC_NONE   = 2'd0,
		SRC_URGENT = 2'd1,
		SRC_JOINT  = 2'd2
	} src_t;

	cts_pkg::uq_cmd_t  uq_cmd;
	cts_pkg::uq_stat_t uq_stat;
	cts_pkg::js_cmd_t  js_cmd;
	cts_pkg::js_stat_t js_stat;
	cts_pkg::frame_t   wr_frame;
	cts_pkg::frame_t   uq_rd;
	cts_pkg::frame_t   js_rd;
	cts_pkg::frame_t   res_frame;

	logic [cts_pkg::CNT_W-1:0]  full_rejects;
	logic [cts_pkg::CNT_W-1:0]  coalesced_total;
	logic [cts_pkg::PEAK_W-1:0] peak_fill;

	logic accept;
	logic frame_ok;
	logic joint_ok;
	logic out_load;
	cts_pkg::status_t status_d;
	src_t src_d;

	// Result stage: one accepted command whose memory read is in flight.
	logic              pend_s1;
	cts_pkg::status_t  status_s1;
	src_t              src_s1;

	// Output register.
	logic              rsp_valid_q;
	cts_pkg::status_t  status_q;
	cts_pkg::frame_t   frame_q;
	logic              prio_q;
	logic [cts_pkg::CNT_W-1:0]  full_q;
	logic [cts_pkg::CNT_W-1:0]  coal_q;
	logic [cts_pkg::PEAK_W-1:0] peak_q;

	// The result stage moves on when the output register is free or being emptied.
	assign out_load  = pend_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !pend_s1 || out_load;
	assign accept    = req.valid && req.ready;

	assign frame_ok = (req.frame_id <= cts_pkg::ID_MAX) && (req.frame_length <= cts_pkg::LEN_MAX);
	assign joint_ok = (req.joint_slot < JOINT_LIMIT);

	assign wr_frame.id      = req.frame_id[cts_pkg::ID_W-1:0];
	assign wr_frame.len     = req.frame_length;
	assign wr_frame.payload = req.frame_payload;

	// Command decode. Validation order follows the frame check, then capacity or joint range.
	always_comb begin
		status_d = cts_pkg::ST_OK;
		src_d    = SRC_NONE;
		uq_cmd   = '0;
		js_cmd   = '0;
		unique case (cts_pkg::mode_t'(req.mode))
			cts_pkg::MODE_URGENT: begin
				if (!frame_ok) begin
					status_d = cts_pkg::ST_BAD_ARG;
				end else if (uq_stat.full) begin
					status_d = cts_pkg::ST_FULL;
					uq_cmd.reject = accept;
				end else begin
					uq_cmd.push = accept;
				end
			end
			cts_pkg::MODE_JOINT: begin
				if (!frame_ok) begin
					status_d = cts_pkg::ST_BAD_ARG;
				end else if (!joint_ok) begin
					status_d = cts_pkg::ST_BAD_JOINT;
				end else begin
					js_cmd.write = accept;
					if (js_stat.hit) begin
						status_d = cts_pkg::ST_REPLACED;
					end
				end
			end
			cts_pkg::MODE_POP: begin
				// Emergency frames always go first; joints only when the FIFO is empty.
				if (!uq_stat.empty) begin
					uq_cmd.pop = accept;
					src_d = SRC_URGENT;
				end else if (js_stat.any_pending) begin
					js_cmd.pop = accept;
					src_d = SRC_JOINT;
				end else begin
					status_d = cts_pkg::ST_EMPTY;
				end
			end
			default: begin
				status_d = cts_pkg::ST_BAD_ARG;
			end
		endcase
	end

	cts_urgent_queue #(
		.DEPTH(URGENT_DEPTH)
	) u_urgent (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (uq_cmd),
		.wr_frame     (wr_frame),
		.stat         (uq_stat),
		.rd_frame     (uq_rd),
		.full_rejects (full_rejects),
		.peak_fill    (peak_fill)
	);

	cts_joint_slots #(
		.COUNT(JOINT_COUNT)
	) u_joints (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (js_cmd),
		.slot            (req.joint_slot[JW-1:0]),
		.wr_frame        (wr_frame),
		.stat            (js_stat),
		.rd_frame        (js_rd),
		.coalesced_total (coalesced_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (accept) begin
			pend_s1 <= 1'b1;
		end else if (out_load) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			src_s1    <= src_d;
		end
	end

	// The frame comes from whichever memory was read; the counters already hold
	// their values after this command because later commands are still waiting.
	always_comb begin
		case (src_s1)
			SRC_URGENT: res_frame = uq_rd;
			SRC_JOINT:  res_frame = js_rd;
			default:    res_frame = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= status_s1;
			frame_q  <= res_frame;
			prio_q   <= (src_s1 == SRC_JOINT);
			full_q   <= full_rejects;
			coal_q   <= coalesced_total;
			peak_q   <= peak_fill;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.out_id          = frame_q.id;
	assign rsp.out_length      = frame_q.len;
	assign rsp.out_payload     = frame_q.payload;
	assign rsp.out_priority    = prio_q;
	assign rsp.full_rejects    = full_q;
	assign rsp.coalesced_total = coal_q;
	assign rsp.peak_fill       = peak_q;

	// Every accepted command occupies the result stage in the next cycle.
	a_accept_to_stage: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_s1)
		else $error("accepted command did not reach the result stage");

	// A joint frame is only ever returned with an ok status.
	a_joint_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_priority |-> rsp.status == cts_pkg::ST_OK)
		else $error("joint frame returned with a non-ok status");

	// An empty pop returns an all-zero frame.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == cts_pkg::ST_EMPTY |->
		rsp.out_id == '0 && rsp.out_length == '0 && rsp.out_payload == '0)
		else $error("empty pop returned frame data");

	// A joint pop is only issued while the emergency FIFO is empty.
	a_joint_after_urgent: assert property (@(posedge clk) disable iff (!arst_n)
		js_cmd.pop |-> uq_stat.empty && !uq_cmd.pop)
		else $error("joint slot served ahead of an emergency frame");
endmodule
`default_nettype wire
